// ----- hdl/brc_pkg.sv -----
`default_nettype none

package brc_pkg;

    // Per-unit state table
    localparam int UNITS    = 1024;
    localparam int UNIT_W   = $clog2(UNITS);
    localparam int SAMPLE_W = 32;
    localparam int REGIME_W = 2;
    localparam int ENTRY_W  = REGIME_W + 1;  // {seen, last regime}

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TWO  = 3'd4;

    // Regime codes
    localparam logic [REGIME_W-1:0] REGIME_LOW  = 2'd0;
    localparam logic [REGIME_W-1:0] REGIME_MID  = 2'd1;
    localparam logic [REGIME_W-1:0] REGIME_HIGH = 2'd2;

    // Mode codes
    localparam logic MODE_TWO   = 1'b0;
    localparam logic MODE_THREE = 1'b1;

    // Comparison results of one sample against the edges
    typedef struct packed {
        logic mode;        // MODE_TWO / MODE_THREE
        logic le_l1;       // q <= low_edge_one
        logic lt_l1;       // q <  low_edge_one
        logic le_u1;       // q <= up_edge_one
        logic le_l2;       // q <= low_edge_two
        logic le_u2;       // q <= up_edge_two
        logic z1_near_up;  // zone one: strictly nearer the upper edge
        logic z1_near_lo;  // zone one: strictly nearer the lower edge
        logic z2_near_lo;  // zone two: strictly nearer the lower edge
    } t_cmp_flags;

endpackage

`default_nettype wire

// ----- hdl/buffered_regime_classifier.sv -----
`default_nettype none
// An accepted transaction passes the stage-1 and output registers before reaching m_axis.
// Throughput: one sample per cycle unless m_axis stalls; the per-unit table does
//   one read and one write each cycle; a one-deep bypass covers back-to-back unit hits.
// Reset: synchronous, active low. After reset a pass clears all 1024 table entries,
//   one entry per cycle; s_axis_tready stays low until it ends.

module buffered_regime_classifier
    import brc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SAMPLE_W-1:0]  i_cfg_wdata,

    // Sample stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,   // [9:0] unit, [41:10] sample, rest 0

    // Regime stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata    // [1:0] regime, rest 0
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                       r_mode;
    logic signed [SAMPLE_W-1:0] r_low_one, r_up_one, r_low_two, r_up_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TWO;
            r_low_one <= '0;
            r_up_one  <= '0;
            r_low_two <= '0;
            r_up_two  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_wdata[0];
                REG_LOW_ONE: r_low_one <= i_cfg_wdata;
                REG_UP_ONE:  r_up_one  <= i_cfg_wdata;
                REG_LOW_TWO: r_low_two <= i_cfg_wdata;
                REG_UP_TWO:  r_up_two  <= i_cfg_wdata;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode and edge comparisons (stage 0)
    // ------------------------------------------------------------------
    logic [UNIT_W-1:0]          in_unit;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_acc;
    t_cmp_flags                 in_flags;

    assign in_unit   = s_axis_tdata[UNIT_W-1:0];
    assign in_sample = s_axis_tdata[UNIT_W +: SAMPLE_W];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    brc_edge_cmp u_edge_cmp (
        .i_mode    (r_mode),
        .i_sample  (in_sample),
        .i_low_one (r_low_one),
        .i_up_one  (r_up_one),
        .i_low_two (r_low_two),
        .i_up_two  (r_up_two),
        .o_flags   (in_flags)
    );

    // ------------------------------------------------------------------
    // Per-unit state table: {seen, last regime}
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] r_tbl [UNITS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               tbl_we;
    logic [UNIT_W-1:0]  tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;

    // Post-reset clearing pass
    logic              r_clr_busy;
    logic [UNIT_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == UNIT_W'(UNITS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        // Read only on accept so the data holds while stage 1 stalls
        if (in_acc) begin
            r_rd_data <= r_tbl[in_unit];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify, write back
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic [UNIT_W-1:0] r_s1_unit;
    t_cmp_flags        r_s1_flags;
    logic              s1_adv;
    logic              s1_fire;

    // Last write-back, bypasses a read that raced it
    logic                r_wb_valid;
    logic [UNIT_W-1:0]   r_wb_unit;
    logic [REGIME_W-1:0] r_wb_regime;

    logic                prev_seen;
    logic [REGIME_W-1:0] prev_regime;
    logic [REGIME_W-1:0] s1_regime;

    logic                r_out_valid;
    logic [REGIME_W-1:0] r_out_regime;

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s1_adv;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_unit  <= in_unit;
            r_s1_flags <= in_flags;
        end
    end

    always_comb begin
        if (r_wb_valid && (r_wb_unit == r_s1_unit)) begin
            prev_seen   = 1'b1;
            prev_regime = r_wb_regime;
        end else begin
            prev_seen   = r_rd_data[REGIME_W];
            prev_regime = r_rd_data[REGIME_W-1:0];
        end
    end

    // Hysteresis rules; a first sample inside a zone goes to the nearer edge
    always_comb begin
        if (r_s1_flags.mode == MODE_TWO) begin
            if (!prev_seen) begin
                if (r_s1_flags.le_l1)            s1_regime = REGIME_LOW;
                else if (!r_s1_flags.le_u1)      s1_regime = REGIME_MID;
                else if (r_s1_flags.z1_near_up)  s1_regime = REGIME_MID;
                else                             s1_regime = REGIME_LOW;
            end else begin
                if (!r_s1_flags.le_u1)           s1_regime = REGIME_MID;
                else if (r_s1_flags.lt_l1)       s1_regime = REGIME_LOW;
                else if (prev_regime != REGIME_LOW) s1_regime = REGIME_MID;
                else                             s1_regime = REGIME_LOW;
            end
        end else begin
            if (r_s1_flags.le_l1) begin
                s1_regime = REGIME_LOW;
            end else if (r_s1_flags.le_u1) begin
                if (!prev_seen) begin
                    s1_regime = r_s1_flags.z1_near_lo ? REGIME_LOW : REGIME_MID;
                end else begin
                    s1_regime = (prev_regime == REGIME_LOW) ? REGIME_LOW : REGIME_MID;
                end
            end else if (r_s1_flags.le_l2) begin
                s1_regime = REGIME_MID;
            end else if (r_s1_flags.le_u2) begin
                if (!prev_seen) begin
                    s1_regime = r_s1_flags.z2_near_lo ? REGIME_MID : REGIME_HIGH;
                end else begin
                    s1_regime = (prev_regime == REGIME_LOW || prev_regime == REGIME_MID)
                                ? REGIME_MID : REGIME_HIGH;
                end
            end else begin
                s1_regime = REGIME_HIGH;
            end
        end
    end

    // Table write: clearing pass or item write-back (never both)
    always_comb begin
        if (r_clr_busy) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_addr;
            tbl_wdata = '0;
        end else begin
            tbl_we    = s1_fire;
            tbl_waddr = r_s1_unit;
            tbl_wdata = {1'b1, s1_regime};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (s1_fire) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_wb_unit   <= r_s1_unit;
            r_wb_regime <= s1_regime;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_regime <= s1_regime;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - REGIME_W){1'b0}}, r_out_regime};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready
    ) else $error("transaction accepted during table clear");

    a_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_s1_valid) |-> !s_axis_tready
    ) else $error("input accepted with full pipeline");

    a_two_mode_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (r_s1_flags.mode == MODE_TWO))
            |=> (m_axis_tdata[REGIME_W-1:0] != REGIME_HIGH)
    ) else $error("regime 2 in two-regime mode");

    a_writeback_tracked: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_wb_valid && m_axis_tvalid)
    ) else $error("write-back not recorded for bypass");

endmodule

`default_nettype wire

// ----- hdl/brc_edge_cmp.sv -----
`default_nettype none

module brc_edge_cmp
    import brc_pkg::*;
(
    input  wire logic                       i_mode,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_low_one,
    input  wire logic signed [SAMPLE_W-1:0] i_up_one,
    input  wire logic signed [SAMPLE_W-1:0] i_low_two,
    input  wire logic signed [SAMPLE_W-1:0] i_up_two,
    output t_cmp_flags                      o_flags
);

    // Nearness inside a zone (l < q <= u): compare u-q with q-l,
    // i.e. the sign of 2q - (l + u). Two extra bits keep it exact.
    logic signed [SAMPLE_W:0]   sum_one;
    logic signed [SAMPLE_W:0]   sum_two;
    logic signed [SAMPLE_W+1:0] twice_q;
    logic signed [SAMPLE_W+1:0] diff_one;
    logic signed [SAMPLE_W+1:0] diff_two;

    always_comb begin
        sum_one  = {i_low_one[SAMPLE_W-1], i_low_one} + {i_up_one[SAMPLE_W-1], i_up_one};
        sum_two  = {i_low_two[SAMPLE_W-1], i_low_two} + {i_up_two[SAMPLE_W-1], i_up_two};
        twice_q  = {i_sample[SAMPLE_W-1], i_sample, 1'b0};
        diff_one = twice_q - {sum_one[SAMPLE_W], sum_one};
        diff_two = twice_q - {sum_two[SAMPLE_W], sum_two};

        o_flags.mode       = i_mode;
        o_flags.le_l1      = (i_sample <= i_low_one);
        o_flags.lt_l1      = (i_sample <  i_low_one);
        o_flags.le_u1      = (i_sample <= i_up_one);
        o_flags.le_l2      = (i_sample <= i_low_two);
        o_flags.le_u2      = (i_sample <= i_up_two);
        o_flags.z1_near_up = (diff_one > 0);
        o_flags.z1_near_lo = diff_one[SAMPLE_W+1];
        o_flags.z2_near_lo = diff_two[SAMPLE_W+1];
    end

endmodule

`default_nettype wire
